// ===== design/amdfs_pkg.sv =====
package amdfs_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int DEPTH_W      = $clog2(MAX_VERTICES + 1);
  localparam int ROW_W        = 16;
  localparam int CNT_W        = 5;
  localparam int CNT_RESET    = 16;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_row;   // write one adjacency row
    logic start;      // begin a walk at vertex 0
    logic push;       // push lowest pending neighbor
    logic emit;       // load output register with current vertex
    logic pop;        // fetch next vertex from the stack
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cand_zero;  // no neighbors left to push
    logic depth_zero; // stack empty
  } dp_stat_t;

  // columns in use, from the vertex count register (0 acts as 1, saturates)
  function automatic logic [ROW_W-1:0] count_mask(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] n;
    logic [ROW_W-1:0] m;
    n = cnt;
    if (n == '0) n = CNT_W'(1);
    if (int'(n) > ROW_W) n = CNT_W'(ROW_W);
    if (int'(n) > MAX_VERTICES) n = CNT_W'(MAX_VERTICES);
    for (int i = 0; i < ROW_W; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

  function automatic logic [VTX_W-1:0] onehot_index(input logic [ROW_W-1:0] oh);
    logic [VTX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (oh[i]) idx = idx | VTX_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== design/amdfs_ctrl.sv =====
module amdfs_ctrl
  import amdfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_mode,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_RUN) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.load_row = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (!stat.cand_zero) begin
          cmd.push = 1'b1;
        end else if (out_free) begin
          cmd.emit = 1'b1;
          if (stat.depth_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.pop = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/amdfs_dp.sv =====
module amdfs_dp
  import amdfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_count,
  input  logic [VTX_W-1:0] in_row_index,
  input  logic [ROW_W-1:0] in_row_bits,
  output logic [VTX_W-1:0] out_vertex,
  output logic             out_last
);

  logic [ROW_W-1:0]   adj_r [MAX_VERTICES];
  logic [VTX_W-1:0]   stack_r [MAX_VERTICES];
  logic [CNT_W-1:0]   count_r;
  logic [ROW_W-1:0]   disc_r, disc_nxt;
  logic [ROW_W-1:0]   cand_r, cand_nxt;
  logic [VTX_W-1:0]   x_r, x_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [VTX_W-1:0]   out_vertex_r;
  logic               out_last_r;

  logic [ROW_W-1:0]   nmask;
  logic [ROW_W-1:0]   low_oh;
  logic [VTX_W-1:0]   low_idx;
  logic [VTX_W-1:0]   pop_idx;
  logic [VTX_W-1:0]   pop_vtx;

  assign nmask   = count_mask(count_r);
  assign low_oh  = cand_r & (~cand_r + ROW_W'(1));
  assign low_idx = onehot_index(low_oh);
  assign pop_idx = VTX_W'(depth_r - DEPTH_W'(1));
  assign pop_vtx = stack_r[pop_idx];

  assign stat.cand_zero  = (cand_r == '0);
  assign stat.depth_zero = (depth_r == '0);
  assign out_vertex      = out_vertex_r;
  assign out_last        = out_last_r;

  always_comb begin
    disc_nxt  = disc_r;
    cand_nxt  = cand_r;
    x_nxt     = x_r;
    depth_nxt = depth_r;
    if (cmd.start) begin
      // vertex 0 is pushed and popped at once
      disc_nxt  = ROW_W'(1);
      x_nxt     = '0;
      depth_nxt = '0;
      cand_nxt  = adj_r[0] & ~ROW_W'(1) & nmask;
    end else if (cmd.push) begin
      disc_nxt  = disc_r | low_oh;
      cand_nxt  = cand_r & ~low_oh;
      depth_nxt = depth_r + DEPTH_W'(1);
    end else if (cmd.pop) begin
      x_nxt     = pop_vtx;
      depth_nxt = depth_r - DEPTH_W'(1);
      cand_nxt  = adj_r[pop_vtx] & ~disc_r & nmask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(CNT_RESET);
      disc_r  <= '0;
      cand_r  <= '0;
      depth_r <= '0;
    end else begin
      if (cfg_we) count_r <= cfg_count;
      disc_r  <= disc_nxt;
      cand_r  <= cand_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (cmd.load_row) adj_r[in_row_index] <= in_row_bits;
    if (cmd.push) stack_r[depth_r[VTX_W-1:0]] <= low_idx;
    if (cmd.emit) begin
      out_vertex_r <= x_r;
      out_last_r   <= stat.depth_zero;
    end
  end

endmodule

// ===== design/adjacency_matrix_dfs.sv =====
// Adjacency-matrix depth-first search.
// Input channel (in_*): one request per item. in_mode = 0 writes in_row_bits
//   into adjacency row in_row_index and produces nothing; in_mode = 1 starts
//   a walk from vertex 0 over the first cfg_vertex_count vertices.
// Output channel (out_*): one result per visited vertex in depth-first order;
//   out_last marks the final vertex of the walk.
// Config channel (cfg_*): cfg_vertex_count, always ready; to be written while
//   idle, not enforced. 0 acts as 1, values above 16 saturate. Reset value 16.
// Flow: a load request leaves in_ready high. A run request is followed by
//   one push per discovered neighbor and one emit per visited vertex; the
//   single push unit takes one neighbor per cycle from a lowest-bit pick.
//   in_ready is low for the whole walk.
// First result: out_valid rises once all of vertex 0's neighbors have been
//   pushed and vertex 0 has been emitted into the output register.
// Stall: the output register holds a result until taken; while it is full
//   and out_ready is low, pending pushes still complete, then the walk waits
//   with its state intact.
// Reset: synchronous, active low; clears the controller, discovered marks and
//   stack pointer and restores the vertex count. Adjacency rows are not
//   cleared and must be loaded before a run uses them.
module adjacency_matrix_dfs
  import amdfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [VTX_W-1:0] in_row_index,
  input  logic [ROW_W-1:0] in_row_bits,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VTX_W-1:0] out_vertex,
  output logic             out_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_vertex_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register write never stalls
  assign cfg_ready = 1'b1;

  amdfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  amdfs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_count    (cfg_vertex_count),
    .in_row_index (in_row_index),
    .in_row_bits  (in_row_bits),
    .out_vertex   (out_vertex),
    .out_last     (out_last)
  );

endmodule

// ===== design/amdfs_checker.sv =====
module amdfs_checker
  import amdfs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_mode,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VTX_W-1:0] out_vertex,
  input logic             out_last,
  input logic             cfg_ready
);

  // a run request makes the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_RUN |=> !in_ready)
    else $error("in_ready high right after a run request");

  // a load request leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_LOAD |=> in_ready)
    else $error("in_ready dropped after a load request");

  // no result after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex) && $stable(out_last))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg_ready low");

endmodule

bind adjacency_matrix_dfs amdfs_checker u_amdfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_mode    (in_mode),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_vertex (out_vertex),
  .out_last   (out_last),
  .cfg_ready  (cfg_ready)
);
